// ===== rtl/scatter_point_blend_plotter_core_assert.svh =====
// Assertion macros shared by the scatter plot blender RTL.
// No dependencies; included by the modules that carry checks.
`ifndef SCATTER_POINT_BLEND_PLOTTER_CORE_ASSERT_SVH
`define SCATTER_POINT_BLEND_PLOTTER_CORE_ASSERT_SVH

// same-cycle implication
`define SPBP_ASSERT_IMP(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("spbp check failed");

// next-cycle implication
`define SPBP_ASSERT_NXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("spbp check failed");

`endif

// ===== rtl/spbp_pkg.sv =====
// Types, codes and helpers for the scatter plot blender.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps

package spbp_pkg;

	localparam int COORD_W  = 32;
	localparam int DIFF_W   = 33;
	localparam int SZ_W     = 9;
	localparam int Q_W      = 9;
	localparam int CNT_W    = 4;
	localparam int NUM_W    = COORD_W + SZ_W;
	localparam int COLOR_W  = 24;
	localparam int CH_W     = 8;
	localparam int IDX_W    = 16;
	localparam int PROD_W   = 2 * SZ_W;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 5;

	// func codes
	localparam logic [1:0] FN_PLOT  = 2'd0;
	localparam logic [1:0] FN_CLEAR = 2'd1;
	localparam logic [1:0] FN_READ  = 2'd2;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_X_LOW       = 3'd0;
	localparam logic [2:0] REG_X_HIGH      = 3'd1;
	localparam logic [2:0] REG_Y_LOW       = 3'd2;
	localparam logic [2:0] REG_Y_HIGH      = 3'd3;
	localparam logic [2:0] REG_PLOT_WIDTH  = 3'd4;
	localparam logic [2:0] REG_PLOT_HEIGHT = 3'd5;

	localparam logic [COORD_W-1:0] LOW_RST  = 32'h0000_0000;
	localparam logic [COORD_W-1:0] HIGH_RST = 32'h0001_0000;
	localparam logic [SZ_W-1:0]    SIZE_RST = 9'd256;

	typedef struct packed {
		logic [1:0]                func;
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic [COLOR_W-1:0]        color;
		logic [IDX_W-1:0]          read_index;
	} cmd_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] pixel_index;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
	} res_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_low;
		logic signed [COORD_W-1:0] x_high;
		logic signed [COORD_W-1:0] y_low;
		logic signed [COORD_W-1:0] y_high;
		logic [SZ_W-1:0]           plot_width;
		logic [SZ_W-1:0]           plot_height;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_BOOT,
		ST_IDLE,
		ST_SUB,
		ST_MUL,
		ST_DIV,
		ST_AXIS,
		ST_INDEX,
		ST_FETCH,
		ST_MERGE,
		ST_WIPE,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic axis;
		logic sub;
		logic mul;
		logic take_axis;
		logic index;
		logic fetch;
		logic merge;
		logic wipe;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic wipe_last;
	} dp_sts_t;

	function automatic logic [CH_W-1:0] half_blend(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		half_blend = {1'b0, a[CH_W-1:1]} + {1'b0, b[CH_W-1:1]};
	endfunction

endpackage

// ===== rtl/spbp_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient known to fit Q_W bits.
// Depends on spbp_pkg and the assertion header.
`timescale 1ns / 1ps
`include "scatter_point_blend_plotter_core_assert.svh"

module spbp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [spbp_pkg::NUM_W-1:0]    num,
	input  logic [spbp_pkg::COORD_W-1:0]  den,
	output logic                          busy,
	output logic [spbp_pkg::Q_W-1:0]      quot
);
	import spbp_pkg::*;

	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsh_q;
	logic [Q_W-1:0]   quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dsh_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			rem_q  <= num;
			dsh_q  <= NUM_W'(den) << (Q_W - 1);
			quot_q <= '0;
			cnt_q  <= CNT_W'(Q_W);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[Q_W-2:0], ge};
			dsh_q  <= dsh_q >> 1;
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

	`SPBP_ASSERT_NXT(a_start_busy, clk, arst_n, start, busy_q)
	`SPBP_ASSERT_NXT(a_last_step, clk, arst_n, busy_q && !start && cnt_q == CNT_W'(1), !busy_q)
	`SPBP_ASSERT_NXT(a_quot_hold, clk, arst_n, !busy_q && !start, $stable(quot_q))

endmodule

// ===== rtl/spbp_ctrl.sv =====
// Sequencer for the blender: steps the datapath through plot, read and clear.
// Depends on spbp_pkg and the assertion header.
`timescale 1ns / 1ps
`include "scatter_point_blend_plotter_core_assert.svh"

module spbp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic [1:0]        cmd_func,
	input  logic              out_free,
	input  spbp_pkg::dp_sts_t sts,
	output spbp_pkg::dp_cmd_t cmd,
	output logic              stall,
	output logic              load_out
);
	import spbp_pkg::*;

	ctrl_state_t st_q, st_d;
	logic        axis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_BOOT;
			axis_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_IDLE) begin
				axis_q <= 1'b0;
			end else if (st_q == ST_AXIS) begin
				axis_q <= 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_BOOT: begin
				if (sts.wipe_last) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd_func)
						FN_PLOT:  st_d = ST_SUB;
						FN_CLEAR: st_d = ST_WIPE;
						FN_READ:  st_d = ST_FETCH;
						default:  st_d = ST_MERGE;
					endcase
				end
			end
			ST_SUB:   st_d = ST_MUL;
			ST_MUL:   st_d = ST_DIV;
			ST_DIV: begin
				if (!sts.div_busy) st_d = ST_AXIS;
			end
			ST_AXIS:  st_d = axis_q ? ST_INDEX : ST_SUB;
			ST_INDEX: st_d = ST_FETCH;
			ST_FETCH: st_d = ST_MERGE;
			ST_MERGE: st_d = ST_DONE;
			ST_WIPE: begin
				if (sts.wipe_last) st_d = ST_MERGE;
			end
			ST_DONE: begin
				if (out_free) st_d = ST_IDLE;
			end
			default:  st_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		cmd.axis  = axis_q;
		stall     = 1'b1;
		load_out  = 1'b0;
		case (st_q)
			ST_BOOT:  cmd.wipe = 1'b1;
			ST_IDLE: begin
				stall    = 1'b0;
				cmd.load = cmd_valid;
			end
			ST_SUB:   cmd.sub = 1'b1;
			ST_MUL:   cmd.mul = 1'b1;
			ST_AXIS:  cmd.take_axis = !sts.div_busy;
			ST_INDEX: cmd.index = 1'b1;
			ST_FETCH: cmd.fetch = 1'b1;
			ST_MERGE: cmd.merge = 1'b1;
			ST_WIPE:  cmd.wipe = 1'b1;
			ST_DONE:  load_out = out_free;
			default:  stall = 1'b1;
		endcase
	end

	`SPBP_ASSERT_IMP(a_div_free, clk, arst_n, cmd.mul, !sts.div_busy)
	`SPBP_ASSERT_NXT(a_leave_idle, clk, arst_n, st_q == ST_IDLE && cmd_valid, st_q != ST_IDLE)
	`SPBP_ASSERT_NXT(a_second_axis, clk, arst_n, st_q == ST_AXIS && !axis_q,
		st_q == ST_SUB && axis_q)

endmodule

// ===== rtl/spbp_dp.sv =====
// Blender datapath: axis mapping, shared divider, pixel store and blend.
// Depends on spbp_pkg and spbp_div.
`timescale 1ns / 1ps

module spbp_dp #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spbp_pkg::dp_cmd_t    cmd,
	input  spbp_pkg::cmd_word_t  word,
	input  spbp_pkg::cfg_t       cfg,
	output spbp_pkg::dp_sts_t    sts,
	output spbp_pkg::res_word_t  res
);
	import spbp_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_word_t word_q;

	logic [SZ_W-1:0] w_eff, h_eff, size;
	logic signed [COORD_W-1:0] coord, lo, hi;

	logic signed [DIFF_W-1:0] diff_s1, span_s1;
	logic [SZ_W-1:0]          size_s1;
	logic                     zero_s2, sat_s2;
	logic [NUM_W-1:0]         prod;
	logic                     div_busy;
	logic [Q_W-1:0]           quot;
	logic [SZ_W-1:0]          axis_val;

	logic [SZ_W-1:0] col_q, row_q;
	logic [AW-1:0]   idx_q;
	logic [AW-1:0]   wipe_q;
	logic            wipe_last;

	logic [COLOR_W-1:0] mem [DEPTH];
	logic [COLOR_W-1:0] rdata_q;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [COLOR_W-1:0] wr_data;
	logic [COLOR_W-1:0] blend;
	logic               rd_ok;
	res_word_t          res_q, res_d;

	// effective plot size
	always_comb begin
		if (cfg.plot_width == '0) begin
			w_eff = SZ_W'(1);
		end else if (int'(cfg.plot_width) > MAX_WIDTH) begin
			w_eff = SZ_W'(MAX_WIDTH);
		end else begin
			w_eff = cfg.plot_width;
		end
		if (cfg.plot_height == '0) begin
			h_eff = SZ_W'(1);
		end else if (int'(cfg.plot_height) > MAX_HEIGHT) begin
			h_eff = SZ_W'(MAX_HEIGHT);
		end else begin
			h_eff = cfg.plot_height;
		end
	end

	assign coord = cmd.axis ? word_q.y_coord : word_q.x_coord;
	assign lo    = cmd.axis ? cfg.y_low : cfg.x_low;
	assign hi    = cmd.axis ? cfg.y_high : cfg.x_high;
	assign size  = cmd.axis ? h_eff : w_eff;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= word;
		end
		if (cmd.sub) begin
			diff_s1 <= $signed({coord[COORD_W-1], coord}) - $signed({lo[COORD_W-1], lo});
			span_s1 <= $signed({hi[COORD_W-1], hi}) - $signed({lo[COORD_W-1], lo});
			size_s1 <= size;
		end
		if (cmd.mul) begin
			zero_s2 <= (span_s1 <= 0) || diff_s1[DIFF_W-1];
			sat_s2  <= diff_s1 >= span_s1;
		end
	end

	// numerator only matters when 0 <= diff < span, so diff fits 32 bits
	assign prod = {{SZ_W{1'b0}}, diff_s1[COORD_W-1:0]} * {{COORD_W{1'b0}}, size_s1};

	spbp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul),
		.num    (prod),
		.den    (span_s1[COORD_W-1:0]),
		.busy   (div_busy),
		.quot   (quot)
	);

	always_comb begin
		if (zero_s2) begin
			axis_val = '0;
		end else if (sat_s2) begin
			axis_val = size_s1 - SZ_W'(1);
		end else begin
			axis_val = quot;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_axis) begin
			if (cmd.axis) begin
				row_q <= axis_val;
			end else begin
				col_q <= axis_val;
			end
		end
		if (cmd.index) begin
			idx_q <= AW'(({{SZ_W{1'b0}}, row_q} * {{SZ_W{1'b0}}, w_eff})
				+ {{SZ_W{1'b0}}, col_q});
		end
	end

	// clearing sweep pointer
	assign wipe_last = (wipe_q == AW'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_q <= '0;
		end else if (cmd.wipe) begin
			wipe_q <= wipe_last ? '0 : wipe_q + AW'(1);
		end
	end

	// pixel store
	assign rd_addr = (word_q.func == FN_READ) ? AW'(word_q.read_index) : idx_q;
	assign blend = {half_blend(word_q.color[23:16], rdata_q[23:16]),
		half_blend(word_q.color[15:8], rdata_q[15:8]),
		half_blend(word_q.color[7:0], rdata_q[7:0])};
	assign wr_en   = cmd.wipe || (cmd.merge && word_q.func == FN_PLOT);
	assign wr_addr = cmd.wipe ? wipe_q : idx_q;
	assign wr_data = cmd.wipe ? '0 : blend;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rd_ok = int'(word_q.read_index) < DEPTH;

	always_comb begin
		res_d = '0;
		case (word_q.func)
			FN_PLOT: begin
				res_d.pixel_index = IDX_W'(idx_q);
				{res_d.red, res_d.green, res_d.blue} = blend;
			end
			FN_READ: begin
				res_d.pixel_index = word_q.read_index;
				if (rd_ok) begin
					{res_d.red, res_d.green, res_d.blue} = rdata_q;
				end
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.merge) begin
			res_q <= res_d;
		end
	end

	assign sts.div_busy  = div_busy;
	assign sts.wipe_last = wipe_last;
	assign res           = res_q;

endmodule

// ===== rtl/scatter_point_blend_plotter_core.sv =====
// One item at a time; the next word is taken the cycle after the result lands
// in the output register. A plot uses the shared divider for both axes, x then
// y, with 9 quotient bits per axis. Reset: async, active low; afterwards a sweep
// over all MAX_WIDTH*MAX_HEIGHT entries zeroes the pixel store with cmd_stall
// high. APB writes are taken throughout.
`timescale 1ns / 1ps

module scatter_point_blend_plotter_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [spbp_pkg::APB_AW-1:0]     paddr,
	input  logic [spbp_pkg::APB_DW-1:0]     pwdata,
	output logic [spbp_pkg::APB_DW-1:0]     prdata,
	output logic                            pready,
	// command words
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  spbp_pkg::cmd_word_t             cmd_word,
	// result words
	output logic                            res_valid,
	input  logic                            res_stall,
	output spbp_pkg::res_word_t             res_word
);
	import spbp_pkg::*;

	cfg_t      cfg_q;
	logic      cfg_wr;
	logic [2:0] reg_sel;

	dp_cmd_t   dp_cmd;
	dp_sts_t   dp_sts;
	res_word_t dp_res;
	logic      load_out;
	logic      out_free;

	res_word_t res_word_q;
	logic      res_valid_q;

	// Register file. Zero wait states; writes land on the access phase.
	assign pready  = 1'b1;
	assign reg_sel = paddr[APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_low       <= LOW_RST;
			cfg_q.x_high      <= HIGH_RST;
			cfg_q.y_low       <= LOW_RST;
			cfg_q.y_high      <= HIGH_RST;
			cfg_q.plot_width  <= SIZE_RST;
			cfg_q.plot_height <= SIZE_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_X_LOW:       cfg_q.x_low       <= pwdata;
				REG_X_HIGH:      cfg_q.x_high      <= pwdata;
				REG_Y_LOW:       cfg_q.y_low       <= pwdata;
				REG_Y_HIGH:      cfg_q.y_high      <= pwdata;
				REG_PLOT_WIDTH:  cfg_q.plot_width  <= pwdata[SZ_W-1:0];
				REG_PLOT_HEIGHT: cfg_q.plot_height <= pwdata[SZ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_X_LOW:       prdata = cfg_q.x_low;
			REG_X_HIGH:      prdata = cfg_q.x_high;
			REG_Y_LOW:       prdata = cfg_q.y_low;
			REG_Y_HIGH:      prdata = cfg_q.y_high;
			REG_PLOT_WIDTH:  prdata = APB_DW'(cfg_q.plot_width);
			REG_PLOT_HEIGHT: prdata = APB_DW'(cfg_q.plot_height);
			default:         prdata = '0;
		endcase
	end

	// Sequencer: owns the command-side handshake and all step timing.
	spbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_func  (cmd_word.func),
		.out_free  (out_free),
		.sts       (dp_sts),
		.cmd       (dp_cmd),
		.stall     (cmd_stall),
		.load_out  (load_out)
	);

	// Datapath: mapping, divider, 24-bit pixel store and blend.
	spbp_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dp_cmd),
		.word   (cmd_word),
		.cfg    (cfg_q),
		.sts    (dp_sts),
		.res    (dp_res)
	);

	// Output register. It parts the two sides: a new command word is accepted
	// while a finished result still waits here; only the hand-off from the
	// datapath waits for the slot to free up.
	assign out_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_word_q <= dp_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule

// ===== tb/sv/scatter_point_blend_plotter_core_tb.sv =====
// Self-checking bench for scatter_point_blend_plotter_core: APB window setup, plot, clear,
// read and unused command words, and a pixel-store predictor that checks each result word.
// Depends on spbp_pkg and the core RTL only.
`timescale 1ns / 1ps

module scatter_point_blend_plotter_core_tb;
	import spbp_pkg::*;

	localparam int MAX_W       = 256;
	localparam int MAX_H       = 256;
	localparam int STORE_DEPTH = MAX_W * MAX_H;
	// longest legal silence is a clear (or the post-reset sweep) plus a stall
	localparam int IDLE_LIMIT  = 4 * STORE_DEPTH;
	localparam int PHASE_WORDS = 229;
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;
	// func code with no operation behind it; the core answers with zeros
	localparam logic [1:0] FN_UNUSED = 2'd3;

	// ------------------------------------------------------------------
	// Predictor: mirror of the window registers and the pixel store,
	// plus the queue of result words still owed by the core.
	// ------------------------------------------------------------------
	class pixel_blend_board;
		logic signed [COORD_W-1:0] x_lo = LOW_RST;
		logic signed [COORD_W-1:0] x_hi = HIGH_RST;
		logic signed [COORD_W-1:0] y_lo = LOW_RST;
		logic signed [COORD_W-1:0] y_hi = HIGH_RST;
		logic [SZ_W-1:0]           cols_reg = SIZE_RST;
		logic [SZ_W-1:0]           rows_reg = SIZE_RST;
		bit [COLOR_W-1:0]          pixels [STORE_DEPTH];
		res_word_t                 owed_pixels [$];
		int unsigned               recent [$];
		int                        errors;

		function void set_reg(input logic [2:0] idx, input logic [APB_DW-1:0] value);
			case (idx)
				REG_X_LOW:       x_lo = value;
				REG_X_HIGH:      x_hi = value;
				REG_Y_LOW:       y_lo = value;
				REG_Y_HIGH:      y_hi = value;
				REG_PLOT_WIDTH:  cols_reg = value[SZ_W-1:0];
				REG_PLOT_HEIGHT: rows_reg = value[SZ_W-1:0];
				default: ;
			endcase
		endfunction

		// zero acts as one, anything past the store dimension saturates
		function int unsigned fit_size(input logic [SZ_W-1:0] s, input int unsigned limit);
			if (s == 0)
				return 1;
			if (s > limit)
				return limit;
			return s;
		endfunction

		function int unsigned cols();
			return fit_size(cols_reg, MAX_W);
		endfunction

		function int unsigned rows();
			return fit_size(rows_reg, MAX_H);
		endfunction

		// (c - lo) * size / (hi - lo), truncated toward zero, clamped to the grid
		function int unsigned scale_axis(input logic signed [COORD_W-1:0] c,
			input logic signed [COORD_W-1:0] lo, input logic signed [COORD_W-1:0] hi,
			input int unsigned size);
			longint span;
			longint q;
			span = longint'(hi) - longint'(lo);
			if (span <= 0)
				return 0;
			q = ((longint'(c) - longint'(lo)) * longint'(size)) / span;
			if (q < 0)
				return 0;
			if (q >= longint'(size))
				return size - 1;
			return int'(q);
		endfunction

		function logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b);
			return (a >> 1) + (b >> 1);
		endfunction

		// called once per accepted command word
		function void take_cmd(input cmd_word_t w);
			res_word_t        r;
			int unsigned      col;
			int unsigned      row;
			int unsigned      idx;
			bit [COLOR_W-1:0] old;
			bit [COLOR_W-1:0] fresh;
			r = '0;
			case (w.func)
				FN_PLOT: begin
					col = scale_axis(w.x_coord, x_lo, x_hi, cols());
					row = scale_axis(w.y_coord, y_lo, y_hi, rows());
					idx = row * cols() + col;
					old = pixels[idx];
					fresh = {mix_channel(w.color[23:16], old[23:16]),
						mix_channel(w.color[15:8], old[15:8]),
						mix_channel(w.color[7:0], old[7:0])};
					pixels[idx] = fresh;
					recent.push_back(idx);
					if (recent.size() > 32)
						void'(recent.pop_front());
					r.pixel_index = idx[IDX_W-1:0];
					{r.red, r.green, r.blue} = fresh;
				end
				FN_CLEAR: begin
					foreach (pixels[i])
						pixels[i] = '0;
				end
				FN_READ: begin
					r.pixel_index = w.read_index;
					{r.red, r.green, r.blue} = pixels[w.read_index];
				end
				default: ;
			endcase
			owed_pixels.push_back(r);
		endfunction

		function void check_pixel(input res_word_t got);
			res_word_t want;
			if (owed_pixels.size() == 0) begin
				$error("result word %h with nothing outstanding", got);
				errors++;
				return;
			end
			want = owed_pixels.pop_front();
			if (got.pixel_index !== want.pixel_index) begin
				$error("pixel_index: expected %0d, got %0d", want.pixel_index, got.pixel_index);
				errors++;
			end
			if (got.red !== want.red) begin
				$error("red: expected %0d, got %0d", want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$error("green: expected %0d, got %0d", want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$error("blue: expected %0d, got %0d", want.blue, got.blue);
				errors++;
			end
		endfunction

		function int pending();
			return owed_pixels.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                cmd_valid;
	logic                cmd_stall;
	cmd_word_t           cmd_word;
	logic                res_valid;
	logic                res_stall;
	res_word_t           res_word;

	pixel_blend_board board = new;
	// set for stretches where neither side inserts gaps
	bit                  quiet;
	int                  clears_left;

	scatter_point_blend_plotter_core #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers. All of them return at a rising edge, so inputs
	// always change right after an edge and are stable at the next one.
	// ------------------------------------------------------------------

	// APB write: setup cycle, then access until pready. psel stays up so
	// back-to-back writes never drop and raise it in the same step.
	task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		board.set_reg(idx, value);
	endtask

	task automatic load_window(input logic signed [COORD_W-1:0] xl, xh, yl, yh,
		input logic [SZ_W-1:0] w, h);
		write_reg(REG_X_LOW, xl);
		write_reg(REG_X_HIGH, xh);
		write_reg(REG_Y_LOW, yl);
		write_reg(REG_Y_HIGH, yh);
		write_reg(REG_PLOT_WIDTH, {{(APB_DW-SZ_W){1'b0}}, w});
		write_reg(REG_PLOT_HEIGHT, {{(APB_DW-SZ_W){1'b0}}, h});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// random gap, then hold the word until the core takes it
	task automatic send_cmd(input cmd_word_t w);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word  <= w;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		board.take_cmd(w);
	endtask

	// unused fields carry random bits so every input bit toggles
	function automatic cmd_word_t noise_word(input logic [1:0] func);
		cmd_word_t w;
		w.func       = func;
		w.x_coord    = $urandom;
		w.y_coord    = $urandom;
		w.color      = COLOR_W'($urandom);
		w.read_index = IDX_W'($urandom);
		return w;
	endfunction

	task automatic plot(input logic signed [COORD_W-1:0] x, y, input logic [COLOR_W-1:0] c);
		cmd_word_t w;
		w         = noise_word(FN_PLOT);
		w.x_coord = x;
		w.y_coord = y;
		w.color   = c;
		send_cmd(w);
	endtask

	task automatic peek(input logic [IDX_W-1:0] idx);
		cmd_word_t w;
		w            = noise_word(FN_READ);
		w.read_index = idx;
		send_cmd(w);
	endtask

	task automatic send_op(input logic [1:0] func);
		send_cmd(noise_word(func));
	endtask

	// drop valid, drain the result queue, then leave the core idle
	// before any register moves
	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// coordinate mostly inside the window (a bit past both ends), sometimes anywhere
	function automatic logic signed [COORD_W-1:0] aim_coord(
		input logic signed [COORD_W-1:0] lo, hi);
		longint span;
		longint pos;
		span = longint'(hi) - longint'(lo);
		if (span <= 0)
			span = 64'sd65536;
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		pos = longint'(lo) - span / 16 + (span * longint'($urandom_range(0, 1151))) / 1024
			+ longint'($urandom_range(0, 4)) - 2;
		if (pos > COORD_MAX)
			pos = COORD_MAX;
		if (pos < COORD_MIN)
			pos = COORD_MIN;
		return pos[COORD_W-1:0];
	endfunction

	// mostly ordered spans, some narrow, some reversed
	task automatic draw_span(output logic signed [COORD_W-1:0] lo, hi);
		logic signed [COORD_W-1:0] a;
		logic signed [COORD_W-1:0] b;
		a = $urandom;
		b = $urandom;
		if ($urandom_range(0, 9) < 3) begin
			lo = a;
			hi = a + $urandom_range(1, 4096);
		end else if ($urandom_range(0, 3) != 0) begin
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
		end else begin
			lo = a;
			hi = b;
		end
	endtask

	// small grids dominate so plots collide and blends stack up
	function automatic logic [SZ_W-1:0] draw_size();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return SZ_W'($urandom_range(1, 16));
		if (r < 9)
			return SZ_W'($urandom_range(1, MAX_W));
		return SZ_W'($urandom_range(0, (1 << SZ_W) - 1));
	endfunction

	task automatic random_phase(input int n);
		int          i;
		int unsigned roll;
		int unsigned sel;
		for (i = 0; i < n; i++) begin
			if (i % 50 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				plot(aim_coord(board.x_lo, board.x_hi), aim_coord(board.y_lo, board.y_hi),
					COLOR_W'($urandom));
			end else if (roll < 94 || (roll >= 97 && clears_left == 0)) begin
				sel = $urandom_range(0, 99);
				if (sel < 60 && board.recent.size() != 0)
					peek(IDX_W'(board.recent[$urandom_range(0, board.recent.size() - 1)]));
				else if (sel < 85)
					peek(IDX_W'($urandom_range(0, board.cols() * board.rows() - 1)));
				else
					peek(IDX_W'($urandom));
			end else if (roll < 97) begin
				send_op(FN_UNUSED);
			end else begin
				// a clear walks the whole store, so only a handful of them
				clears_left--;
				send_op(FN_CLEAR);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random stall per word, every accepted word checked.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int unsigned hold;
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 8);
			if (hold != 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (res_valid !== 1'b1);
			board.check_pixel(res_word);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: ends the run if neither channel moves for too long.
	// ------------------------------------------------------------------
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid === 1'b1 && cmd_stall === 1'b0) ||
				(res_valid === 1'b1 && res_stall === 1'b0))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		int                        p;
		logic signed [COORD_W-1:0] xl;
		logic signed [COORD_W-1:0] xh;
		logic signed [COORD_W-1:0] yl;
		logic signed [COORD_W-1:0] yh;
		logic [SZ_W-1:0]           w;
		logic [SZ_W-1:0]           h;

		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		cmd_valid <= 1'b0;
		cmd_word  <= '0;
		quiet       = 1'b0;
		clears_left = 4;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words on the reset window: x and y in 0..1.0, 256x256 grid.
		// First word waits out the post-reset wipe.
		peek('0);
		peek('1);
		plot(32'sh0, 32'sh0, 24'hFF_FFFF);            // blend into a zero pixel
		plot(32'sh0, 32'sh0, 24'hFF_FFFF);            // blend onto itself
		plot(32'sh0, 32'sh0, 24'h01_0101);            // low bits of the new color drop
		plot(32'sh0_FFFF, 32'sh1_0000, 24'hFF_0000);  // last column, row clamps at the edge
		plot(32'sh8000_0000, 32'sh7FFF_FFFF, 24'h00_FF00);  // coordinate extremes
		plot(32'sh7FFF_FFFF, 32'sh8000_0000, 24'h00_00FF);
		plot(-32'sd1, -32'sd256, 24'h12_3456);        // truncation toward zero, negative clamp
		plot(32'sh100, 32'shFF, 24'hAB_CDEF);         // exact column step vs. just below
		plot(32'shFF00, 32'sh8000, 24'h80_8080);
		send_op(FN_UNUSED);
		peek(16'd0);
		peek(16'd1);
		peek(16'hFF00);
		peek(16'd255);
		send_op(FN_CLEAR);
		peek(16'd0);
		peek(16'hFFFF);
		plot(32'sh8000, 32'sh8000, 24'hFF_FFFF);
		peek(16'h8080);
		settle();

		// Random phases, each on its own window. The first few pin down the
		// extremes: full range, single pixel with a reversed axis, zero span
		// with out-of-range sizes, and a very narrow window.
		for (p = 0; p < 8; p++) begin
			case (p)
				0: begin
					xl = 32'sh8000_0000; xh = 32'sh7FFF_FFFF;
					yl = 32'sh8000_0000; yh = 32'sh7FFF_FFFF;
					w = 9'd256; h = 9'd256;
				end
				1: begin
					xl = 32'sh0; xh = 32'sh1_0000;
					yl = 32'sh1_0000; yh = 32'sh0;
					w = 9'd1; h = 9'd1;
				end
				2: begin
					xl = 32'sh5_0000; xh = 32'sh5_0000;
					yl = -32'sh8000; yh = 32'sh8000;
					w = 9'd0; h = 9'd511;
				end
				3: begin
					xl = -32'sd5; xh = 32'sd5;
					yl = 32'sd0; yh = 32'sd1000;
					w = 9'd300; h = 9'd3;
				end
				default: begin
					draw_span(xl, xh);
					draw_span(yl, yh);
					w = draw_size();
					h = draw_size();
				end
			endcase
			load_window(xl, xh, yl, yh, w, h);
			random_phase(PHASE_WORDS);
			settle();
		end

		// let anything the core still does show up as a stray result word
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/spbp_pkg.sv
rtl/spbp_div.sv
rtl/spbp_ctrl.sv
rtl/spbp_dp.sv
rtl/scatter_point_blend_plotter_core.sv
tb/sv/scatter_point_blend_plotter_core_tb.sv
